// ===== sv/lfp_pkg.sv =====
// Shared types and constants for the length-prefixed frame parser.
`default_nettype none

package lfp_pkg;

    // Defaults for the top-level parameters.
    localparam int unsigned FIELD_CAP_DEF      = 16;
    localparam int unsigned MAX_LEN_DIGITS_DEF = 5;

    // Reset value of the field limit register.
    localparam int unsigned FIELD_LIMIT_RST = 16;

    // Frame syntax characters and length bounds.
    localparam logic [7:0]  CHAR_VERSION = 8'h31;
    localparam logic [7:0]  CHAR_BAR     = 8'h7C;
    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam logic [7:0]  CHAR_NINE    = 8'h39;
    localparam logic [16:0] LEN_MAX      = 17'd99999;
    localparam logic [16:0] LEN_SAT      = 17'd100000;

    // Type letters, first letter in the top byte.
    localparam logic [23:0] TYPE_NAM = 24'h4E414D;
    localparam logic [23:0] TYPE_SET = 24'h534554;
    localparam logic [23:0] TYPE_MSG = 24'h4D5347;
    localparam logic [23:0] TYPE_WHO = 24'h57484F;

    typedef enum logic [2:0] {
        KIND_NAM     = 3'd0,
        KIND_SET     = 3'd1,
        KIND_MSG     = 3'd2,
        KIND_WHO     = 3'd3,
        KIND_UNKNOWN = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_VERSION   = 3'd1,
        ERR_SEPARATOR = 3'd2,
        ERR_LENGTH    = 3'd3,
        ERR_ZERO_LEN  = 3'd4,
        ERR_NO_BAR    = 3'd5,
        ERR_TRUNCATED = 3'd6
    } t_err;

    // One result item.
    typedef struct packed {
        t_kind       msg_kind;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic [3:0]  field_index;
        logic        field_end;
        logic        frame_done;
        logic [4:0]  field_count;
        t_err        error_code;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/lfp_core.sv =====
// Frame parser state and per-byte result logic.
`default_nettype none

module lfp_core #(
    parameter int unsigned FIELD_CAP      = lfp_pkg::FIELD_CAP_DEF,
    parameter int unsigned MAX_LEN_DIGITS = lfp_pkg::MAX_LEN_DIGITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [4:0]       i_cfg_data,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic             i_conn_closed,
    output lfp_pkg::t_result      o_res
);

    localparam int unsigned CFW = $clog2(FIELD_CAP + 1);
    localparam int unsigned DCW = $clog2(MAX_LEN_DIGITS + 1);
    localparam int unsigned LW  = (CFW > 5) ? CFW : 5;

    typedef enum logic [3:0] {
        PH_VER  = 4'd0,
        PH_SEP1 = 4'd1,
        PH_T0   = 4'd2,
        PH_T1   = 4'd3,
        PH_T2   = 4'd4,
        PH_SEP2 = 4'd5,
        PH_LEN  = 4'd6,
        PH_BODY = 4'd7,
        PH_DEAD = 4'd8
    } t_phase;

    function automatic lfp_pkg::t_kind kind_of(input logic [23:0] t);
        lfp_pkg::t_kind k;
        if (t == lfp_pkg::TYPE_NAM)      k = lfp_pkg::KIND_NAM;
        else if (t == lfp_pkg::TYPE_SET) k = lfp_pkg::KIND_SET;
        else if (t == lfp_pkg::TYPE_MSG) k = lfp_pkg::KIND_MSG;
        else if (t == lfp_pkg::TYPE_WHO) k = lfp_pkg::KIND_WHO;
        else                             k = lfp_pkg::KIND_UNKNOWN;
        return k;
    endfunction

    t_phase            r_phase, n_phase;
    logic [15:0]       r_type, n_type;
    lfp_pkg::t_kind    r_kind, n_kind;
    logic [16:0]       r_len, n_len;
    logic [DCW-1:0]    r_digits, n_digits;
    logic [16:0]       r_left, n_left;
    logic [CFW-1:0]    r_cur, n_cur;
    logic [4:0]        r_limit;

    lfp_pkg::t_result  res;
    logic [20:0]       len_acc;
    logic              is_bar;
    logic              is_digit;
    logic              last;
    logic              kept;

    assign is_bar   = (i_rx_byte == lfp_pkg::CHAR_BAR);
    assign is_digit = (i_rx_byte >= lfp_pkg::CHAR_ZERO) && (i_rx_byte <= lfp_pkg::CHAR_NINE);
    // Ten times the length so far plus the new digit, as two shifted adds.
    assign len_acc  = {1'b0, r_len, 3'b000} + {3'b000, r_len, 1'b0}
                    + {17'd0, i_rx_byte[3:0]};
    assign last     = (r_left <= 17'd1);
    assign kept     = (LW'(r_cur) < LW'(r_limit)) && (LW'(r_cur) < LW'(FIELD_CAP));

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_kind   = r_kind;
        n_len    = r_len;
        n_digits = r_digits;
        n_left   = r_left;
        n_cur    = r_cur;
        res      = '0;

        if (i_conn_closed) begin
            if (r_phase != PH_VER && r_phase != PH_DEAD) begin
                res.error_code = lfp_pkg::ERR_TRUNCATED;
            end
            n_phase  = PH_VER;
            n_len    = '0;
            n_digits = '0;
            n_left   = '0;
            n_cur    = '0;
        end else begin
            unique case (r_phase)
                PH_VER: begin
                    if (i_rx_byte == lfp_pkg::CHAR_VERSION) begin
                        n_phase = PH_SEP1;
                    end else begin
                        res.error_code = lfp_pkg::ERR_VERSION;
                        n_phase        = PH_DEAD;
                    end
                end
                PH_SEP1: begin
                    if (is_bar) begin
                        n_phase = PH_T0;
                    end else begin
                        res.error_code = lfp_pkg::ERR_SEPARATOR;
                        n_phase        = PH_DEAD;
                    end
                end
                PH_T0: begin
                    n_type  = {r_type[7:0], i_rx_byte};
                    n_phase = PH_T1;
                end
                PH_T1: begin
                    n_type  = {r_type[7:0], i_rx_byte};
                    n_phase = PH_T2;
                end
                PH_T2: begin
                    // All three letters are in; classify once here.
                    n_kind  = kind_of({r_type, i_rx_byte});
                    n_phase = PH_SEP2;
                end
                PH_SEP2: begin
                    if (is_bar) begin
                        n_phase  = PH_LEN;
                        n_len    = '0;
                        n_digits = '0;
                    end else begin
                        res.error_code = lfp_pkg::ERR_SEPARATOR;
                        n_phase        = PH_DEAD;
                    end
                end
                PH_LEN: begin
                    if (is_bar) begin
                        if (r_digits == '0) begin
                            res.error_code = lfp_pkg::ERR_LENGTH;
                            n_phase        = PH_DEAD;
                        end else if (r_len == '0) begin
                            res.error_code = lfp_pkg::ERR_ZERO_LEN;
                            n_phase        = PH_DEAD;
                        end else if (r_len > lfp_pkg::LEN_MAX) begin
                            res.error_code = lfp_pkg::ERR_LENGTH;
                            n_phase        = PH_DEAD;
                        end else begin
                            n_left  = r_len;
                            n_cur   = '0;
                            n_phase = PH_BODY;
                        end
                    end else if (r_digits >= DCW'(MAX_LEN_DIGITS) || !is_digit) begin
                        res.error_code = lfp_pkg::ERR_LENGTH;
                        n_phase        = PH_DEAD;
                    end else begin
                        n_len    = (len_acc > {4'd0, lfp_pkg::LEN_SAT}) ? lfp_pkg::LEN_SAT
                                                                        : len_acc[16:0];
                        n_digits = r_digits + DCW'(1);
                    end
                end
                PH_BODY: begin
                    if (last && !is_bar) begin
                        res.error_code = lfp_pkg::ERR_NO_BAR;
                        n_phase        = PH_DEAD;
                    end else begin
                        res.msg_kind = r_kind;
                        if (kept) begin
                            res.field_index = 4'(r_cur);
                        end
                        if (is_bar) begin
                            if (kept) begin
                                res.field_end = 1'b1;
                                n_cur         = r_cur + CFW'(1);
                            end
                        end else if (kept) begin
                            res.data_valid = 1'b1;
                            res.data_byte  = i_rx_byte;
                        end
                        if (last) begin
                            res.frame_done  = 1'b1;
                            res.field_count = 5'(n_cur);
                            n_phase         = PH_VER;
                            n_len           = '0;
                            n_digits        = '0;
                            n_left          = '0;
                            n_cur           = '0;
                        end else begin
                            n_left = r_left - 17'd1;
                        end
                    end
                end
                PH_DEAD: begin
                    n_phase = PH_DEAD;
                end
                default: begin
                    n_phase = PH_DEAD;
                end
            endcase
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_VER;
            r_type   <= '0;
            r_kind   <= lfp_pkg::KIND_NAM;
            r_len    <= '0;
            r_digits <= '0;
            r_left   <= '0;
            r_cur    <= '0;
            r_limit  <= 5'(lfp_pkg::FIELD_LIMIT_RST);
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_fire) begin
                r_phase  <= n_phase;
                r_type   <= n_type;
                r_kind   <= n_kind;
                r_len    <= n_len;
                r_digits <= n_digits;
                r_left   <= n_left;
                r_cur    <= n_cur;
            end
        end
    end

`ifndef SYNTHESIS
    // An error result carries nothing but the code.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && res.error_code != lfp_pkg::ERR_NONE)
            |-> (!res.data_valid && !res.field_end && !res.frame_done))
        else $error("error result carries payload");

    // A close always returns the parser to the version byte.
    a_close_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_conn_closed) |=> (r_phase == PH_VER && r_cur == '0))
        else $error("close did not reset the parser");

    // A dead parser emits all-zero results on ordinary bytes.
    a_dead_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_conn_closed && r_phase == PH_DEAD) |-> (res == '0))
        else $error("dead parser produced output");

    // A frame end always leaves the parser ready for the next version byte.
    a_done_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && res.frame_done) |=> (r_phase == PH_VER))
        else $error("frame end did not restart the parser");
`endif

endmodule

`default_nettype wire

// ===== sv/lfp_skid.sv =====
// Two-entry output stage that decouples the parser from the result receiver.
`default_nettype none

module lfp_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire lfp_pkg::t_result  i_in_data,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output lfp_pkg::t_result       o_out_data,
    input  wire logic              i_out_ready
);

    logic             r_out_valid;
    logic             r_skid_valid;
    lfp_pkg::t_result r_out;
    lfp_pkg::t_result r_skid;
    logic             in_fire;
    logic             out_free;

    assign o_in_ready  = !r_skid_valid;
    assign in_fire     = i_in_valid && !r_skid_valid;
    assign out_free    = i_out_ready || !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_in_data;
        end else if (in_fire) begin
            r_skid <= i_in_data;
        end
    end

`ifndef SYNTHESIS
    // The skid entry is only ever used behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    // The skid entry only fills when the output register was stalled.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid entry filled without a stall");

    // A held skid entry moves to the output as soon as it is taken.
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not drained");
`endif

endmodule

`default_nettype wire

// ===== sv/length_prefixed_frame_parser.sv =====
// Top level of the length-prefixed frame parser.
//
// One received byte enters per item on the input channel (i_valid/o_ready),
// together with a connection-closed flag; a close ignores the byte and
// returns the parser to waiting for a version byte, reporting truncation if
// a frame was under way. Every accepted item gives exactly one result item
// on the output channel (o_valid/i_ready): the frame kind, a body byte
// tagged with its field index, field-end and frame-done flags, the kept
// field count and an error code.
// The byte is parsed by a short block of logic against the parser state and
// the result is written into the output register, or into the skid entry if
// that register is stalled. One item can be taken in every cycle while
// o_ready is high. A two-entry output stage means a stalled receiver only
// holds back the input after two results are waiting; o_ready is a register.
// Synchronous reset (i_rst_n low) empties the output stage, sets the field
// limit to sixteen and returns the parser to waiting for a version byte.
// The field limit is written through i_cfg_we/i_cfg_data at any clock edge,
// and is meant to change only while the block is idle.
`default_nettype none

module length_prefixed_frame_parser #(
    parameter int unsigned FIELD_CAP      = lfp_pkg::FIELD_CAP_DEF,
    parameter int unsigned MAX_LEN_DIGITS = lfp_pkg::MAX_LEN_DIGITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_conn_closed,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_msg_kind,
    output logic [7:0]       o_data_byte,
    output logic             o_data_valid,
    output logic [3:0]       o_field_index,
    output logic             o_field_end,
    output logic             o_frame_done,
    output logic [4:0]       o_field_count,
    output logic [2:0]       o_error_code
);

    logic             in_fire;
    logic             in_ready;
    lfp_pkg::t_result core_res;
    lfp_pkg::t_result out_res;

    // An item is taken whenever the output stage has room for its result.
    assign o_ready = in_ready;
    assign in_fire = i_valid && in_ready;

    lfp_core #(
        .FIELD_CAP      (FIELD_CAP),
        .MAX_LEN_DIGITS (MAX_LEN_DIGITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_fire        (in_fire),
        .i_rx_byte     (i_rx_byte),
        .i_conn_closed (i_conn_closed),
        .o_res         (core_res)
    );

    lfp_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_data   (core_res),
        .o_in_ready  (in_ready),
        .o_out_valid (o_valid),
        .o_out_data  (out_res),
        .i_out_ready (i_ready)
    );

    assign o_msg_kind    = out_res.msg_kind;
    assign o_data_byte   = out_res.data_byte;
    assign o_data_valid  = out_res.data_valid;
    assign o_field_index = out_res.field_index;
    assign o_field_end   = out_res.field_end;
    assign o_frame_done  = out_res.frame_done;
    assign o_field_count = out_res.field_count;
    assign o_error_code  = out_res.error_code;

endmodule

`default_nettype wire

// ===== sim/tb_length_prefixed_frame_parser.sv =====
// Self-checking testbench for the length-prefixed frame parser, directed and random.
`timescale 1ns / 100ps

module tb_length_prefixed_frame_parser;
    import lfp_pkg::*;

    // A stretch this long with no item moving on either channel means the block has hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Rough number of live input items in the random part of the run.
    localparam int RANDOM_ITEMS   = 800;
    // Length of the long receiver hold-off in the back-pressure test.
    localparam int HOLD_CYCLES    = 300;

    // Byte positions within a frame header.
    localparam int POS_SEP1   = 1;
    localparam int POS_SEP2   = 5;
    localparam int POS_DIGITS = 6;

    // Parser phases of the predictor.
    typedef enum logic [3:0] {
        ST_VERSION,
        ST_SEP1,
        ST_TYPE0,
        ST_TYPE1,
        ST_TYPE2,
        ST_SEP2,
        ST_LENGTH,
        ST_BODY,
        ST_DEAD
    } t_rx_phase;

    // Ways in which a frame is broken on purpose.
    typedef enum int {
        FAULT_VERSION,
        FAULT_SEP1,
        FAULT_SEP2,
        FAULT_NO_DIGITS,
        FAULT_NON_DIGIT,
        FAULT_TOO_MANY,
        FAULT_ZERO_LEN,
        FAULT_BAD_END,
        FAULT_TRUNCATE
    } t_fault;

    // One input item as the sender offers it.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       closed;
    } t_rx_item;

    // Every input is given a known value from time zero.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [4:0]  i_cfg_data    = '0;
    logic        i_valid       = 1'b0;
    logic        i_ready       = 1'b0;
    logic [7:0]  i_rx_byte     = '0;
    logic        i_conn_closed = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_msg_kind;
    logic [7:0]  o_data_byte;
    logic        o_data_valid;
    logic [3:0]  o_field_index;
    logic        o_field_end;
    logic        o_frame_done;
    logic [4:0]  o_field_count;
    logic [2:0]  o_error_code;

    // Predicted parser state, kept in step with the block item by item.
    t_rx_phase   rx_phase   = ST_VERSION;
    logic [23:0] type_ltrs  = '0;
    logic [16:0] len_val    = '0;
    logic [2:0]  len_digits = '0;
    logic [16:0] body_left  = '0;
    logic [4:0]  cur_field  = '0;
    logic [4:0]  field_lim  = 5'(FIELD_LIMIT_RST);

    // Results still owed by the block, oldest first, and the frame being assembled.
    t_result     pending_results[$];
    t_rx_item    frame_q[$];

    int          mismatch_count = 0;
    int          live_items     = 0;
    int          idle_cycles    = 0;
    int          rx_stall_left  = 0;
    int          rx_hold_left   = 0;
    bit          idling         = 1'b1;

    length_prefixed_frame_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .i_conn_closed (i_conn_closed),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_msg_kind    (o_msg_kind),
        .o_data_byte   (o_data_byte),
        .o_data_valid  (o_data_valid),
        .o_field_index (o_field_index),
        .o_field_end   (o_field_end),
        .o_frame_done  (o_frame_done),
        .o_field_count (o_field_count),
        .o_error_code  (o_error_code)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Back to waiting for a version byte, with the frame state cleared.
    function automatic void clear_frame();
        rx_phase   = ST_VERSION;
        type_ltrs  = '0;
        len_val    = '0;
        len_digits = '0;
        body_left  = '0;
        cur_field  = '0;
    endfunction

    // Works out the one result that a byte (or a close) produces, and moves the
    // predicted parser on. Any error leaves every other field at zero.
    function automatic t_result parse_rx_byte(input logic [7:0] rx_b, input logic closed);
        t_result r;
        logic    last;
        logic    kept;
        int      lim;
        int      grown;
        r = '0;
        if (closed) begin
            // A close inside a frame is a truncation; between frames or while
            // dead it is silent. Either way the parser starts afresh.
            if (rx_phase != ST_VERSION && rx_phase != ST_DEAD) begin
                r.error_code = ERR_TRUNCATED;
            end
            clear_frame();
            return r;
        end
        case (rx_phase)
            ST_VERSION: begin
                if (rx_b == CHAR_VERSION) begin
                    rx_phase = ST_SEP1;
                end else begin
                    r.error_code = ERR_VERSION;
                    rx_phase = ST_DEAD;
                end
            end
            ST_SEP1: begin
                if (rx_b == CHAR_BAR) begin
                    rx_phase = ST_TYPE0;
                end else begin
                    r.error_code = ERR_SEPARATOR;
                    rx_phase = ST_DEAD;
                end
            end
            ST_TYPE0, ST_TYPE1, ST_TYPE2: begin
                // Any byte will do as a type letter; the first ends up on top.
                type_ltrs = {type_ltrs[15:0], rx_b};
                rx_phase = t_rx_phase'(rx_phase + 1);
            end
            ST_SEP2: begin
                if (rx_b == CHAR_BAR) begin
                    rx_phase   = ST_LENGTH;
                    len_val    = '0;
                    len_digits = '0;
                end else begin
                    r.error_code = ERR_SEPARATOR;
                    rx_phase = ST_DEAD;
                end
            end
            ST_LENGTH: begin
                if (rx_b == CHAR_BAR) begin
                    if (len_digits == 0) begin
                        r.error_code = ERR_LENGTH;
                        rx_phase = ST_DEAD;
                    end else if (len_val == 0) begin
                        r.error_code = ERR_ZERO_LEN;
                        rx_phase = ST_DEAD;
                    end else if (len_val > LEN_MAX) begin
                        r.error_code = ERR_LENGTH;
                        rx_phase = ST_DEAD;
                    end else begin
                        body_left = len_val;
                        cur_field = '0;
                        rx_phase  = ST_BODY;
                    end
                end else if (len_digits >= MAX_LEN_DIGITS_DEF || rx_b < CHAR_ZERO ||
                             rx_b > CHAR_NINE) begin
                    r.error_code = ERR_LENGTH;
                    rx_phase = ST_DEAD;
                end else begin
                    // The running value saturates just above the largest length.
                    grown = int'(len_val) * 10 + int'(rx_b) - int'(CHAR_ZERO);
                    if (grown > int'(LEN_SAT)) begin
                        grown = int'(LEN_SAT);
                    end
                    len_val = grown[16:0];
                    len_digits++;
                end
            end
            ST_BODY: begin
                last = (body_left <= 17'd1);
                lim  = (int'(field_lim) < FIELD_CAP_DEF) ? int'(field_lim) : FIELD_CAP_DEF;
                kept = (int'(cur_field) < lim);
                if (last && rx_b != CHAR_BAR) begin
                    r.error_code = ERR_NO_BAR;
                    rx_phase = ST_DEAD;
                end else begin
                    case (type_ltrs)
                        TYPE_NAM: r.msg_kind = KIND_NAM;
                        TYPE_SET: r.msg_kind = KIND_SET;
                        TYPE_MSG: r.msg_kind = KIND_MSG;
                        TYPE_WHO: r.msg_kind = KIND_WHO;
                        default:  r.msg_kind = KIND_UNKNOWN;
                    endcase
                    if (kept) begin
                        r.field_index = cur_field[3:0];
                    end
                    if (rx_b == CHAR_BAR) begin
                        if (kept) begin
                            r.field_end = 1'b1;
                            cur_field++;
                        end
                    end else if (kept) begin
                        r.data_valid = 1'b1;
                        r.data_byte  = rx_b;
                    end
                    if (last) begin
                        r.frame_done  = 1'b1;
                        r.field_count = cur_field;
                        clear_frame();
                    end else begin
                        body_left--;
                    end
                end
            end
            default: begin
                // Dead: the byte is ignored until a close comes.
                rx_phase = ST_DEAD;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic string describe(input t_result r);
        return $sformatf("kind %0d byte %02h valid %0b index %0d end %0b done %0b count %0d err %0d",
                         r.msg_kind, r.data_byte, r.data_valid, r.field_index, r.field_end,
                         r.frame_done, r.field_count, r.error_code);
    endfunction

    // Only the first ten are printed in full; the rest are just counted.
    function automatic void report_mismatch(input string what, input t_result want,
                                            input t_result seen);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected %s, got %s", $time, what, describe(want),
                     describe(seen));
        end
    endfunction

    // Each result that the receiver takes is matched against the oldest
    // prediction. Outputs and i_ready are read as they stood before the edge.
    always @(posedge i_clk) begin : result_check
        t_result seen;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            seen.msg_kind    = t_kind'(o_msg_kind);
            seen.data_byte   = o_data_byte;
            seen.data_valid  = o_data_valid;
            seen.field_index = o_field_index;
            seen.field_end   = o_field_end;
            seen.frame_done  = o_frame_done;
            seen.field_count = o_field_count;
            seen.error_code  = t_err'(o_error_code);
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, seen);
            end else begin
                want = pending_results.pop_front();
                if (seen.msg_kind !== want.msg_kind || seen.data_byte !== want.data_byte ||
                    seen.data_valid !== want.data_valid ||
                    seen.field_index !== want.field_index ||
                    seen.field_end !== want.field_end || seen.frame_done !== want.frame_done ||
                    seen.field_count !== want.field_count ||
                    seen.error_code !== want.error_code) begin
                    report_mismatch("result mismatch", want, seen);
                end
            end
        end
    end

    // The receiver: ready unless a long hold-off is running or a random stall
    // burst has been drawn.
    always @(posedge i_clk) begin : receiver
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(0, 7);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Ends the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sending
    // ------------------------------------------------------------------

    // Offers one item and holds it until the block takes it; the prediction is
    // made at the edge of acceptance. Valid stays high for a following item.
    task automatic send_rx(input logic [7:0] rx_b, input logic closed);
        if (idling && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_rx_byte     <= rx_b;
        i_conn_closed <= closed;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // Bytes swallowed by a dead parser do not count as live stimulus.
        if (closed || rx_phase != ST_DEAD) begin
            live_items++;
        end
        pending_results.push_back(parse_rx_byte(rx_b, closed));
    endtask

    // Stops offering and waits until every predicted result has been taken.
    // One result follows each item, so the block is idle at that point.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_field_limit(input logic [4:0] lim);
        wait_for_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        field_lim  = lim;
    endtask

    function automatic void push_byte(input logic [7:0] rx_b);
        frame_q.push_back(t_rx_item'{rx_byte: rx_b, closed: 1'b0});
    endfunction

    function automatic logic [7:0] other_than(input logic [7:0] avoid);
        logic [7:0] v;
        v = 8'($urandom);
        if (v == avoid) begin
            v = v ^ 8'h01;
        end
        return v;
    endfunction

    // A byte that is neither a digit nor a bar.
    function automatic logic [7:0] non_digit();
        logic [7:0] v;
        do begin
            v = 8'($urandom);
        end while ((v >= CHAR_ZERO && v <= CHAR_NINE) || v == CHAR_BAR);
        return v;
    endfunction

    // Assembles a frame in frame_q. The length is written in decimal, padded with
    // leading zeros to pad_to digits, and the body ends in a bar; elsewhere in the
    // body a byte is a bar with a chance of bar_pct percent.
    function automatic void build_frame(input logic [23:0] typ, input int body_bytes,
                                        input int pad_to, input int bar_pct);
        logic [7:0] digits[$];
        int         v;
        v = body_bytes;
        frame_q.delete();
        do begin
            digits.push_front(8'(int'(CHAR_ZERO) + v % 10));
            v = v / 10;
        end while (v > 0);
        while (digits.size() < pad_to) digits.push_front(CHAR_ZERO);
        push_byte(CHAR_VERSION);
        push_byte(CHAR_BAR);
        push_byte(typ[23:16]);
        push_byte(typ[15:8]);
        push_byte(typ[7:0]);
        push_byte(CHAR_BAR);
        foreach (digits[i]) push_byte(digits[i]);
        push_byte(CHAR_BAR);
        for (int i = 0; i < body_bytes; i++) begin
            if (i == body_bytes - 1 || $urandom_range(0, 99) < bar_pct) begin
                push_byte(CHAR_BAR);
            end else begin
                push_byte(8'($urandom));
            end
        end
    endfunction

    // The four known kinds, arbitrary letters, and near misses one bit off.
    function automatic logic [23:0] pick_type();
        logic [23:0] t;
        case ($urandom_range(0, 5))
            0:       t = TYPE_NAM;
            1:       t = TYPE_SET;
            2:       t = TYPE_MSG;
            3:       t = TYPE_WHO;
            4:       t = 24'($urandom);
            default: t = ($urandom_range(0, 1) ? TYPE_SET : TYPE_WHO) ^
                         (24'd1 << $urandom_range(0, 23));
        endcase
        return t;
    endfunction

    // Mostly short bodies, now and then a few hundred bytes.
    function automatic int pick_body_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) begin
            return $urandom_range(1, 24);
        end else if (r < 98) begin
            return $urandom_range(25, 120);
        end
        return $urandom_range(121, 400);
    endfunction

    function automatic int length_digits();
        int n;
        n = 0;
        while (frame_q[POS_DIGITS + n].rx_byte != CHAR_BAR) n++;
        return n;
    endfunction

    task automatic send_frame_q();
        foreach (frame_q[i]) send_rx(frame_q[i].rx_byte, frame_q[i].closed);
    endtask

    task automatic send_good_frame(input logic [23:0] typ, input int body_bytes,
                                   input int pad_to, input int bar_pct);
        build_frame(typ, body_bytes, pad_to, bar_pct);
        send_frame_q();
    endtask

    // Sends a frame broken in the given way, then a close. After an error a few
    // bytes of noise go to the dead parser first; a truncated frame is simply
    // cut short, so the close lands inside it.
    task automatic send_faulty_frame(input t_fault fault);
        int cut;
        build_frame(pick_type(), pick_body_len(), $urandom_range(1, 5), $urandom_range(0, 50));
        case (fault)
            FAULT_VERSION:   frame_q[0].rx_byte = other_than(CHAR_VERSION);
            FAULT_SEP1:      frame_q[POS_SEP1].rx_byte = other_than(CHAR_BAR);
            FAULT_SEP2:      frame_q[POS_SEP2].rx_byte = other_than(CHAR_BAR);
            FAULT_NO_DIGITS: repeat (length_digits()) frame_q.delete(POS_DIGITS);
            FAULT_NON_DIGIT: frame_q[POS_DIGITS + $urandom_range(0, length_digits() - 1)].rx_byte =
                                 non_digit();
            FAULT_TOO_MANY:  build_frame(pick_type(), pick_body_len(), $urandom_range(6, 8), 30);
            FAULT_ZERO_LEN:  build_frame(pick_type(), 0, $urandom_range(1, 5), 0);
            FAULT_BAD_END:   frame_q[frame_q.size() - 1].rx_byte = other_than(CHAR_BAR);
            default: begin
                cut = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > cut) void'(frame_q.pop_back());
            end
        endcase
        if (fault != FAULT_TRUNCATE) begin
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
        end
        send_frame_q();
        send_rx(8'($urandom), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Well-formed frames of every kind, the shortest body, padded lengths and
    // the extreme byte values, plus a close between frames.
    task automatic test_frame_kinds();
        int body_at;
        send_good_frame(TYPE_NAM, 6, 1, 30);
        send_good_frame(TYPE_SET, 9, 2, 30);
        send_good_frame(TYPE_MSG, 12, 1, 30);
        send_good_frame(TYPE_WHO, 4, 3, 30);
        send_good_frame(24'h414243, 7, 1, 30);
        // Type letters that are themselves bars still only give an unknown kind.
        send_good_frame(24'h7C7C7C, 3, 1, 0);
        // A body of one byte, the closing bar alone.
        send_good_frame(TYPE_WHO, 1, 1, 0);
        // Five digits with leading zeros, and body bytes at both extremes.
        build_frame(TYPE_MSG, 5, 5, 0);
        body_at = frame_q.size() - 5;
        frame_q[body_at].rx_byte     = 8'h00;
        frame_q[body_at + 1].rx_byte = 8'hFF;
        frame_q[body_at + 2].rx_byte = CHAR_BAR;
        frame_q[body_at + 3].rx_byte = 8'h7D;
        send_frame_q();
        // A close between frames is silent.
        send_rx(8'hFF, 1'b1);
        send_rx(8'h00, 1'b1);
    endtask

    // Each kind of malformed frame, and truncation at several random points.
    task automatic test_frame_faults();
        for (int f = FAULT_VERSION; f < FAULT_TRUNCATE; f++) begin
            send_faulty_frame(t_fault'(f));
        end
        repeat (6) send_faulty_frame(FAULT_TRUNCATE);
    endtask

    // Frames, one of them with more fields than the block keeps, under limits that cover zero, one,
    // the reset value and values beyond the number of fields the block keeps.
    task automatic test_field_limits();
        logic [4:0] limits[5];
        limits = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd16};
        foreach (limits[i]) begin
            set_field_limit(limits[i]);
            send_good_frame(TYPE_SET, 24, 2, 100);
            send_good_frame(TYPE_MSG, 30, 1, 40);
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering,
    // so the output stage fills and the input stalls; the sender then pauses
    // until everything has come back.
    task automatic test_backpressure();
        idling = 1'b0;
        rx_hold_left = HOLD_CYCLES;
        send_good_frame(TYPE_NAM, 40, 1, 25);
        wait_for_results();
        idling = 1'b1;
    endtask

    // The largest length that five digits allow is loaded into the body counter;
    // the frame is cut a little way into its body, so the close is a truncation.
    task automatic test_longest_frame();
        build_frame(TYPE_MSG, 99999, 5, 2);
        while (frame_q.size() > POS_DIGITS + 6 + 24) void'(frame_q.pop_back());
        send_frame_q();
        send_rx(8'($urandom), 1'b1);
    endtask

    // Random streams, mostly well-formed frames with the odd broken one, in
    // phases under different field limits. Two phases run without idling, the
    // last of them closing the run.
    task automatic test_random_streams();
        logic [4:0] limits[6];
        int         goal;
        limits = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd1, 5'd12};
        for (int p = 0; p < 6; p++) begin
            set_field_limit(limits[p]);
            idling = (p != 2 && p != 5);
            goal = live_items + RANDOM_ITEMS / 6;
            while (live_items < goal) begin
                if ($urandom_range(0, 99) < 78) begin
                    send_good_frame(pick_type(), pick_body_len(), $urandom_range(1, 5),
                                    $urandom_range(0, 60));
                    if ($urandom_range(0, 9) == 0) begin
                        send_rx(8'($urandom), 1'b1);
                    end
                end else begin
                    send_faulty_frame(t_fault'($urandom_range(0, FAULT_TRUNCATE)));
                end
            end
        end
    endtask

    // Reset is applied once at the start, and the tests then run in turn.
    initial begin : run
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_frame_kinds();
        test_frame_faults();
        test_field_limits();
        test_backpressure();
        test_longest_frame();
        test_random_streams();
        wait_for_results();
        // A few more cycles to catch any result the block should not give.
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/lfp_pkg.sv
sv/lfp_core.sv
sv/lfp_skid.sv
sv/length_prefixed_frame_parser.sv
sim/tb_length_prefixed_frame_parser.sv
